[rtl/lfm_pkg.sv]
// ----------------------------------------------------------------------------
// lfm_pkg
// Shared widths and the tick_rate reset value of the mailbox and fps meter.
// ----------------------------------------------------------------------------
package lfm_pkg;

	localparam int FIELD_W = 32;
	localparam int CNT_W   = 32;
	localparam int RATE_W  = 17;
	localparam int PROD_W  = CNT_W + RATE_W;

	localparam logic [RATE_W-1:0] TICK_RATE_RST = RATE_W'(1000);

endpackage

[rtl/lfm_ifs.sv]
// ----------------------------------------------------------------------------
// lfm_ifs
// Valid/ready channels of the mailbox: event input, result output, config.
// ----------------------------------------------------------------------------
interface lfm_evt_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [lfm_pkg::FIELD_W-1:0] frame_addr;
	logic [lfm_pkg::FIELD_W-1:0] tick_now;

	modport source (output valid, func, frame_addr, tick_now, input ready);
	modport sink   (input valid, func, frame_addr, tick_now, output ready);
endinterface

interface lfm_res_if;
	logic                        valid;
	logic                        ready;
	logic [lfm_pkg::FIELD_W-1:0] fetched_addr;
	logic                        fetched_valid;
	logic [lfm_pkg::CNT_W-1:0]   frame_total;
	logic [lfm_pkg::CNT_W-1:0]   fps_value;
	logic                        frame_pending;

	modport source (output valid, fetched_addr, fetched_valid, frame_total, fps_value,
		frame_pending, input ready);
	modport sink   (input valid, fetched_addr, fetched_valid, frame_total, fps_value,
		frame_pending, output ready);
endinterface

interface lfm_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lfm_pkg::RATE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[rtl/lfm_mul.sv]
// ----------------------------------------------------------------------------
// lfm_mul
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lfm_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lfm_pkg::CNT_W-1:0]   a,
	input  logic [lfm_pkg::RATE_W-1:0]  b,
	output logic [lfm_pkg::PROD_W-1:0]  prod,
	output logic                        done
);

	localparam int CW = $clog2(lfm_pkg::RATE_W);
	localparam logic [CW-1:0] LAST = CW'(lfm_pkg::RATE_W - 1);

	logic [lfm_pkg::PROD_W-1:0] acc_q;
	logic [lfm_pkg::CNT_W-1:0]  mcand_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lfm_pkg::CNT_W:0]    hi_sum;

	always_comb begin
		hi_sum = {1'b0, acc_q[lfm_pkg::PROD_W-1:lfm_pkg::RATE_W]};
		if (acc_q[0]) begin
			hi_sum = hi_sum + {1'b0, mcand_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// shift the product right one bit per step, adding the multiplicand on a one
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= {{lfm_pkg::CNT_W{1'b0}}, b};
			mcand_q <= a;
		end else if (busy_q) begin
			acc_q <= {hi_sum, acc_q[lfm_pkg::RATE_W-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

[rtl/lfm_div.sv]
// ----------------------------------------------------------------------------
// lfm_div
// Bit-serial restoring divider: one quotient bit per cycle, 32-bit quotient.
// The high part of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module lfm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lfm_pkg::PROD_W-1:0]  dividend,
	input  logic [lfm_pkg::CNT_W-1:0]   divisor,
	output logic [lfm_pkg::CNT_W-1:0]   quotient,
	output logic                        done
);

	localparam int CW = $clog2(lfm_pkg::CNT_W);
	localparam logic [CW-1:0] LAST = CW'(lfm_pkg::CNT_W - 1);

	logic [lfm_pkg::CNT_W-1:0] rem_q;
	logic [lfm_pkg::CNT_W-1:0] quo_q;
	logic [lfm_pkg::CNT_W-1:0] dsor_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [lfm_pkg::CNT_W:0]   trial;
	logic [lfm_pkg::CNT_W:0]   diff;
	logic                      fits;

	always_comb begin
		trial = {rem_q, quo_q[lfm_pkg::CNT_W-1]};
		diff  = trial - {1'b0, dsor_q};
		fits  = (trial >= {1'b0, dsor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= lfm_pkg::CNT_W'(dividend[lfm_pkg::PROD_W-1:lfm_pkg::CNT_W]);
			quo_q  <= dividend[lfm_pkg::CNT_W-1:0];
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[lfm_pkg::CNT_W-1:0] : trial[lfm_pkg::CNT_W-1:0];
			quo_q <= {quo_q[lfm_pkg::CNT_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[rtl/latest_frame_mailbox_fps_meter.sv]
// ----------------------------------------------------------------------------
// latest_frame_mailbox_fps_meter
// Latest-frame mailbox with a windowed frame-rate meter.
// ----------------------------------------------------------------------------
// Usage:
//   evt  (sink)  : one word per event; func 0 = frame done with frame_addr and
//                  tick_now, func 1 = consumer fetch. A zero address is ignored.
//   res  (source): exactly one result word per event, in order.
//   cfg  (sink)  : tick_rate write, always ready; write only while idle.
// Sequencing:
//   A fetch or a frame that does not close the window passes from acceptance
//   through S_EXEC and S_FIN into the output register that drives res.valid.
//   A frame that closes the window adds a serial multiply (one tick_rate bit
//   per step) and a serial divide (one quotient bit per step) between S_EXEC
//   and S_FIN. One event is in work at a time; the next is accepted the cycle
//   after the result enters the output register.
// Reset:
//   All counters, the flag and the stored address clear; tick_rate is 1000.
// Stall:
//   A pending result holds in the output register; the event channel keeps
//   accepting one more event, whose result waits until the register frees.
// ----------------------------------------------------------------------------
module latest_frame_mailbox_fps_meter #(
	parameter int ADDR_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	lfm_cfg_if.sink   cfg,
	lfm_evt_if.sink   evt,
	lfm_res_if.source res
);

	localparam int FW     = lfm_pkg::FIELD_W;
	localparam int KEEP_W = (ADDR_WIDTH < FW) ? ADDR_WIDTH : FW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]                  state_q;
	logic                        func_q;
	logic [FW-1:0]               addr_q;
	logic [FW-1:0]               now_q;
	logic [lfm_pkg::RATE_W-1:0]  rate_q;
	logic [KEEP_W-1:0]           latest_q;
	logic                        new_q;
	logic [lfm_pkg::CNT_W-1:0]   total_q;
	logic [lfm_pkg::CNT_W-1:0]   wf_q;
	logic [lfm_pkg::CNT_W-1:0]   ws_q;
	logic [lfm_pkg::CNT_W-1:0]   fps_q;
	logic [lfm_pkg::CNT_W-1:0]   elapsed_q;
	logic [FW-1:0]               fa_q;
	logic                        fv_q;

	logic                        res_valid_q;
	logic [FW-1:0]               res_fa_q;
	logic                        res_fv_q;
	logic [lfm_pkg::CNT_W-1:0]   res_total_q;
	logic [lfm_pkg::CNT_W-1:0]   res_fps_q;
	logic                        res_pend_q;

	logic [lfm_pkg::CNT_W-1:0]   wf_nxt;
	logic [lfm_pkg::CNT_W-1:0]   elapsed;
	logic                        close_win;
	logic                        frame_ok;
	logic                        mul_start;
	logic                        div_start;
	logic                        mul_done;
	logic                        div_done;
	logic [lfm_pkg::PROD_W-1:0]  prod;
	logic [lfm_pkg::CNT_W-1:0]   quo;
	logic                        out_free;

	assign cfg.ready = 1'b1;
	assign evt.ready = (state_q == S_IDLE);

	always_comb begin
		frame_ok  = !func_q && (addr_q[KEEP_W-1:0] != '0);
		wf_nxt    = wf_q + lfm_pkg::CNT_W'(1);
		elapsed   = now_q - ws_q;
		close_win = (elapsed >= lfm_pkg::CNT_W'(rate_q));
		mul_start = (state_q == S_EXEC) && frame_ok && close_win;
		div_start = (state_q == S_MUL) && mul_done;
		out_free  = !res_valid_q || res.ready;
	end

	lfm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (wf_nxt),
		.b      (rate_q),
		.prod   (prod),
		.done   (mul_done)
	);

	lfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (elapsed_q),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= lfm_pkg::TICK_RATE_RST;
		end else if (cfg.valid && cfg.ready) begin
			rate_q <= cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			func_q <= evt.func;
			addr_q <= evt.frame_addr;
			now_q  <= evt.tick_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			latest_q  <= '0;
			new_q     <= 1'b0;
			total_q   <= '0;
			wf_q      <= '0;
			ws_q      <= '0;
			fps_q     <= '0;
			elapsed_q <= '0;
			fa_q      <= '0;
			fv_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (evt.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= mul_start ? S_MUL : S_FIN;
					fa_q    <= (func_q && new_q) ? FW'(latest_q) : '0;
					fv_q    <= func_q && new_q;
					if (func_q) begin
						new_q <= 1'b0;
					end else if (frame_ok) begin
						latest_q <= addr_q[KEEP_W-1:0];
						new_q    <= 1'b1;
						total_q  <= total_q + lfm_pkg::CNT_W'(1);
						if (close_win) begin
							wf_q      <= '0;
							ws_q      <= now_q;
							elapsed_q <= elapsed;
						end else begin
							wf_q <= wf_nxt;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						fps_q   <= (elapsed_q == '0) ? '0 : quo;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			res_fa_q    <= fa_q;
			res_fv_q    <= fv_q;
			res_total_q <= total_q;
			res_fps_q   <= fps_q;
			res_pend_q  <= new_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.fetched_addr  = res_fa_q;
	assign res.fetched_valid = res_fv_q;
	assign res.frame_total   = res_total_q;
	assign res.fps_value     = res_fps_q;
	assign res.frame_pending = res_pend_q;

endmodule

[rtl/lfm_checker.sv]
// ----------------------------------------------------------------------------
// lfm_checker
// Port-level checks on the result channel of the mailbox.
// ----------------------------------------------------------------------------
module lfm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [lfm_pkg::FIELD_W-1:0] fetched_addr,
	input logic                        fetched_valid,
	input logic                        frame_pending
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(fetched_addr))
		else $error("result word dropped or changed while stalled");

	a_fetch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fetched_valid |-> fetched_addr != '0)
		else $error("fetched frame with zero address");

	a_no_fetch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !fetched_valid |-> fetched_addr == '0)
		else $error("address shown without a fetched frame");

	a_fetch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fetched_valid |-> !frame_pending)
		else $error("flag still set after a successful fetch");

endmodule

bind latest_frame_mailbox_fps_meter lfm_checker u_lfm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.fetched_addr  (res.fetched_addr),
	.fetched_valid (res.fetched_valid),
	.frame_pending (res.frame_pending)
);
